// ===== hdl/mavg_pkg.sv =====
`timescale 1ns / 1ps
// mavg_pkg: shared types and constants for the moving average core
// no dependencies

package mavg_pkg;

    localparam int SAMPLE_W = 16;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/moving_average_warmup_core.sv =====
`timescale 1ns / 1ps
// moving_average_warmup_core: sliding-window mean of signed 16-bit samples
// depends on mavg_pkg, mavg_cell, mavg_div
//
// Each sample transfer shifts the sample into a chain of WINDOW_SIZE cells and
// updates a running sum (oldest sample out, new one in); the result is the sum
// divided by the number of samples held so far, truncated toward zero, so the
// first WINDOW_SIZE results average only the samples seen. The result comes
// from the bit-serial divider, with SUM_W = 16 + clog2(WINDOW_SIZE); no sample
// is taken while the divider is busy. The next sample is taken as soon as the
// divider has handed its result to the output register.

module moving_average_warmup_core #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] o_average
);
    import mavg_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

    logic signed [SAMPLE_W-1:0] w_tap [0:WINDOW_SIZE];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]           r_fill;
    logic [CNT_W-1:0]           n_fill;
    logic                       w_accept;
    t_div_ctl                   w_ctl;
    t_div_stat                  w_stat;
    logic signed [SAMPLE_W-1:0] w_quotient;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_average;

    assign w_tap[0] = i_sample;

    for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
        mavg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_d     (w_tap[k]),
            .o_q     (w_tap[k+1])
        );
    end

    assign o_stall  = w_stat.busy;
    assign w_accept = i_valid & ~w_stat.busy;

    assign n_sum  = r_sum - SUM_W'(w_tap[WINDOW_SIZE]) + SUM_W'(i_sample);
    assign n_fill = (r_fill == CNT_W'(WINDOW_SIZE)) ? r_fill : r_fill + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
        end
    end

    assign w_ctl.start = w_accept;
    assign w_ctl.take  = ~r_out_valid | ~i_stall;

    mavg_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_stat     (w_stat),
        .o_quotient (w_quotient)
    );

    // output register parts the divider from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done && w_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done && w_ctl.take) begin
            r_average <= w_quotient;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

endmodule

// ===== hdl/mavg_cell.sv =====
`timescale 1ns / 1ps
// mavg_cell: one stage of the sample window shift chain
// depends on mavg_pkg

module mavg_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0] i_d,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] o_q
);
    import mavg_pkg::*;

    logic signed [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/mavg_div.sv =====
`timescale 1ns / 1ps
// mavg_div: bit-serial signed divider, one quotient bit per cycle
// depends on mavg_pkg

module mavg_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mavg_pkg::t_div_ctl                   i_ctl,
    input  logic signed [SUM_W-1:0]              i_dividend,
    input  logic        [CNT_W-1:0]              i_divisor,
    output mavg_pkg::t_div_stat                  o_stat,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] o_quotient
);
    import mavg_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    t_div_state          r_state;
    t_div_state          n_state;
    logic                r_neg;
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    w_mag;
    logic [CNT_W:0]      w_trial;
    logic [CNT_W:0]      w_diff;
    logic                w_ge;
    logic [SUM_W-1:0]    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stat  = '0;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_ctl.start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                o_stat.busy = 1'b1;
                if (r_step == '0) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                o_stat.busy = 1'b1;
                o_stat.done = 1'b1;
                if (i_ctl.take) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_ctl.start) begin
            r_neg  <= i_dividend[SUM_W-1];
            r_quo  <= w_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= STEP_W'(SUM_W - 1);
        end else if (r_state == DIV_RUN) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], w_ge};
            r_step <= r_step - 1'b1;
        end
    end

    // magnitude of the mean never exceeds 2^15, so the low bits carry it
    assign w_res      = r_neg ? SUM_W'(-r_quo) : r_quo;
    assign o_quotient = w_res[SAMPLE_W-1:0];

endmodule
